/* hdl/lhs_pkg.sv */
`timescale 1ns / 1ps

package lhs_pkg;

    // Field widths fixed by the stream and register layout.
    localparam int LAT_W      = 48;
    localparam int SUM_W      = 64;
    localparam int COUNT_W    = 32;
    localparam int IDX_W      = 10;
    localparam int WIDTH_US_W = 16;
    localparam int NBUCKET_W  = 11;
    localparam int BREAK_US_W = 24;

    // Nanoseconds in one microsecond, and the widths of the scaled values.
    localparam int NS_PER_US  = 1000;
    localparam int NS_MULT_W  = 10;
    localparam int DIV_W      = WIDTH_US_W + NS_MULT_W;
    localparam int BREAK_NS_W = BREAK_US_W + NS_MULT_W;

    // Stream payload widths.
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 248;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_HIST_ENABLE     = 2'd0;
    localparam logic [1:0] REG_BUCKET_WIDTH_US = 2'd1;
    localparam logic [1:0] REG_NUM_BUCKETS     = 2'd2;
    localparam logic [1:0] REG_BREAK_US        = 2'd3;

    // Register reset values.
    localparam logic [WIDTH_US_W-1:0] BUCKET_WIDTH_US_RST = 16'd10;
    localparam logic [NBUCKET_W-1:0]  NUM_BUCKETS_RST     = 11'd1024;
    localparam logic [BREAK_US_W-1:0] BREAK_US_RST        = 24'd1000000;

    // Default values for the top-level parameters.
    localparam int HIST_DEPTH_DEF   = 1024;
    localparam int WARMUP_LIMIT_DEF = 42;

endpackage

/* hdl/latency_histogram_stats.sv */
`timescale 1ns / 1ps

// Round-trip latency statistics. Each sample transfer (tuser 0) advances a
// saturating round counter; once the warm-up rounds are past, the sample is
// added to a saturating 64-bit sum, updates min and max, may raise
// threshold_hit, and, with the histogram enabled, increments one 32-bit bucket.
// A read transfer (tuser 1) returns one bucket count. Each input transfer gives
// exactly one result transfer carrying a snapshot of all statistics. The block
// takes one item at a time. A counted sample with the histogram enabled and a
// nonzero bucket width goes through the stats step, the bit-serial restoring
// divider that finds the bucket (one quotient bit per cycle), the bucket step,
// the memory read and the memory write; with a zero width the division is
// skipped. Other samples go from the stats step to the result, and bucket
// reads through the memory read. The next input is accepted in the cycle after
// the result is loaded, and a result still waiting on m_tready holds the
// following item at its last step. After reset the bucket memory is cleared
// one entry per cycle ahead of the first item; register writes go in meanwhile.
module latency_histogram_stats #(
    parameter int HIST_DEPTH   = lhs_pkg::HIST_DEPTH_DEF,
    parameter int WARMUP_LIMIT = lhs_pkg::WARMUP_LIMIT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [47:0] latency_ns, [57:48] bucket_index, [63:58] zero
    input  logic [lhs_pkg::S_DATA_W-1:0]    s_tdata,
    // [0] func
    input  logic                            s_tuser,

    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] threshold_hit, [1] sample_counted, [33:2] read_count,
    // [81:34] rounds_seen, [129:82] min_seen, [177:130] max_seen,
    // [241:178] sum_seen, [247:242] zero
    output logic [lhs_pkg::M_DATA_W-1:0]    m_tdata,

    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lhs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lhs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lhs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    import lhs_pkg::*;

    localparam int ADDR_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int STEP_W = $clog2(LAT_W);

    localparam logic [ADDR_W-1:0]  ADDR_LAST  = ADDR_W'(HIST_DEPTH - 1);
    localparam logic [LAT_W-1:0]   LAT_MAX    = {LAT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [STEP_W-1:0]  STEP_LAST  = STEP_W'(LAT_W - 1);
    localparam logic [LAT_W-1:0]   WARMUP_LAT = LAT_W'(WARMUP_LIMIT);

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_STATS  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_BUCKET = 3'd4;
    localparam logic [2:0] ST_MEMRD  = 3'd5;
    localparam logic [2:0] ST_MEMWR  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    // Control and statistics state.
    logic [2:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     mem_addr_reg, mem_addr_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  hist_enable_reg;
    logic [WIDTH_US_W-1:0] bucket_width_us_reg;
    logic [NBUCKET_W-1:0]  num_buckets_reg;
    logic [BREAK_US_W-1:0] break_us_reg;
    logic [LAT_W-1:0]      round_reg, round_next;
    logic [LAT_W-1:0]      min_reg, min_next;
    logic [LAT_W-1:0]      max_reg, max_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;

    // Item payload and working registers.
    logic                  func_reg, func_next;
    logic [LAT_W-1:0]      lat_reg, lat_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  counted_reg, counted_next;
    logic                  hit_reg, hit_next;
    logic [DIV_W-1:0]      div_reg, div_next;
    logic [BREAK_NS_W-1:0] brk_ns_reg, brk_ns_next;
    logic [LAT_W-1:0]      quo_reg, quo_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [M_DATA_W-1:0]   out_reg, out_next;

    // Bucket memory.
    logic [COUNT_W-1:0]    hist_mem [HIST_DEPTH];
    logic [COUNT_W-1:0]    rd_data_reg;
    logic                  wr_en;
    logic [COUNT_W-1:0]    wr_data;

    // Combinational helpers.
    logic                  cfg_write;
    logic                  s_accept;
    logic [LAT_W-1:0]      round_sat;
    logic [SUM_W:0]        sum_add;
    logic [DIV_W:0]        trial;
    logic                  trial_ge;
    logic [ADDR_W-1:0]     used_last;
    logic [ADDR_W-1:0]     bucket;
    logic                  idx_ok;
    logic [COUNT_W-1:0]    read_count;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;
    assign pready   = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            REG_HIST_ENABLE:     prdata = APB_DATA_W'(hist_enable_reg);
            REG_BUCKET_WIDTH_US: prdata = APB_DATA_W'(bucket_width_us_reg);
            REG_NUM_BUCKETS:     prdata = APB_DATA_W'(num_buckets_reg);
            REG_BREAK_US:        prdata = APB_DATA_W'(break_us_reg);
            default:             prdata = '0;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_enable_reg     <= 1'b0;
            bucket_width_us_reg <= BUCKET_WIDTH_US_RST;
            num_buckets_reg     <= NUM_BUCKETS_RST;
            break_us_reg        <= BREAK_US_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_HIST_ENABLE:     hist_enable_reg     <= pwdata[0];
                REG_BUCKET_WIDTH_US: bucket_width_us_reg <= pwdata[WIDTH_US_W-1:0];
                REG_NUM_BUCKETS:     num_buckets_reg     <= pwdata[NBUCKET_W-1:0];
                REG_BREAK_US:        break_us_reg        <= pwdata[BREAK_US_W-1:0];
                default:             hist_enable_reg     <= hist_enable_reg;
            endcase
        end
    end

    // Shared datapath pieces.
    always_comb
    begin
        round_sat = (round_reg != LAT_MAX) ? round_reg + LAT_W'(1) : round_reg;
        sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(lat_reg);

        // One restoring division step: shift in the next dividend bit and
        // subtract the bucket width when it fits.
        trial    = {rem_reg, quo_reg[LAT_W-1]};
        trial_ge = (trial >= {1'b0, div_reg});

        // Last bucket in use, after clamping the count to 1..HIST_DEPTH.
        if (num_buckets_reg == '0)
        begin
            used_last = '0;
        end
        else if (32'(num_buckets_reg) > 32'(HIST_DEPTH))
        begin
            used_last = ADDR_LAST;
        end
        else
        begin
            used_last = ADDR_W'(num_buckets_reg - NBUCKET_W'(1));
        end

        // A zero width sends the sample to the last bucket.
        if (div_reg == '0 || quo_reg >= LAT_W'(used_last))
        begin
            bucket = used_last;
        end
        else
        begin
            bucket = ADDR_W'(quo_reg);
        end

        idx_ok     = (32'(idx_reg) < 32'(HIST_DEPTH));
        read_count = (func_reg && idx_ok) ? rd_data_reg : '0;
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        mem_addr_next = mem_addr_reg;
        step_next     = step_reg;
        m_valid_next  = m_valid_reg;
        round_next    = round_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        sum_next      = sum_reg;
        func_next     = func_reg;
        lat_next      = lat_reg;
        idx_next      = idx_reg;
        counted_next  = counted_reg;
        hit_next      = hit_reg;
        div_next      = div_reg;
        brk_ns_next   = brk_ns_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        out_next      = out_reg;
        wr_en         = 1'b0;
        wr_data       = '0;

        // The result register empties on a completed output transfer.
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                mem_addr_next = mem_addr_reg + ADDR_W'(1);
                if (mem_addr_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_accept)
                begin
                    func_next    = s_tuser;
                    lat_next     = s_tdata[LAT_W-1:0];
                    idx_next     = s_tdata[LAT_W+IDX_W-1:LAT_W];
                    hit_next     = 1'b0;
                    counted_next = 1'b0;
                    if (s_tuser)
                    begin
                        mem_addr_next = ADDR_W'(s_tdata[LAT_W+IDX_W-1:LAT_W]);
                        state_next    = ST_MEMRD;
                    end
                    else
                    begin
                        round_next   = round_sat;
                        counted_next = (round_sat >= WARMUP_LAT);
                        div_next     = DIV_W'(bucket_width_us_reg * NS_MULT_W'(NS_PER_US));
                        brk_ns_next  = BREAK_NS_W'(break_us_reg * NS_MULT_W'(NS_PER_US));
                        state_next   = ST_STATS;
                    end
                end
            end

            ST_STATS:
            begin
                state_next = ST_DONE;
                if (counted_reg)
                begin
                    sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                    if (lat_reg < min_reg)
                    begin
                        min_next = lat_reg;
                    end
                    if (lat_reg > max_reg)
                    begin
                        max_next = lat_reg;
                        hit_next = (break_us_reg != '0) && (lat_reg > LAT_W'(brk_ns_reg));
                    end
                    if (hist_enable_reg)
                    begin
                        quo_next   = lat_reg;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = (div_reg == '0) ? ST_BUCKET : ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                quo_next  = {quo_reg[LAT_W-2:0], trial_ge};
                rem_next  = trial_ge ? DIV_W'(trial - {1'b0, div_reg}) : trial[DIV_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_BUCKET;
                end
            end

            ST_BUCKET:
            begin
                mem_addr_next = bucket;
                state_next    = ST_MEMRD;
            end

            ST_MEMRD:
            begin
                state_next = func_reg ? ST_DONE : ST_MEMWR;
            end

            ST_MEMWR:
            begin
                wr_en      = 1'b1;
                wr_data    = (rd_data_reg != COUNT_MAX) ? rd_data_reg + COUNT_W'(1)
                                                        : rd_data_reg;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    out_next     = {6'd0, sum_reg, max_reg, min_reg, round_reg,
                                    read_count, counted_reg, hit_reg};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and statistics registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            mem_addr_reg <= '0;
            step_reg     <= '0;
            m_valid_reg  <= 1'b0;
            round_reg    <= '0;
            min_reg      <= LAT_MAX;
            max_reg      <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mem_addr_reg <= mem_addr_next;
            step_reg     <= step_next;
            m_valid_reg  <= m_valid_next;
            round_reg    <= round_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            sum_reg      <= sum_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        lat_reg     <= lat_next;
        idx_reg     <= idx_next;
        counted_reg <= counted_next;
        hit_reg     <= hit_next;
        div_reg     <= div_next;
        brk_ns_reg  <= brk_ns_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        out_reg     <= out_next;
    end

    // Bucket memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[mem_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MEMRD)
        begin
            rd_data_reg <= hist_mem[mem_addr_reg];
        end
    end

endmodule

/* dv/latency_histogram_stats_test.sv */
`timescale 1ns / 1ps

module latency_histogram_stats_test;

    localparam int HIST_DEPTH     = lhs_pkg::HIST_DEPTH_DEF;
    localparam int WARMUP_COUNT   = lhs_pkg::WARMUP_LIMIT_DEF;
    localparam int QUIET_LIMIT    = 5000;
    localparam bit FUNC_SAMPLE    = 1'b0;
    localparam bit FUNC_READ      = 1'b1;

    // One result transfer, unpacked into its fields.
    typedef struct packed {
        logic        threshold_hit;
        logic        sample_counted;
        logic [31:0] read_count;
        logic [47:0] rounds;
        logic [47:0] min_ns;
        logic [47:0] max_ns;
        logic [63:0] sum_ns;
    } stats_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [lhs_pkg::S_DATA_W-1:0]       s_tdata = '0;
    logic                               s_tuser = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [lhs_pkg::M_DATA_W-1:0]       m_tdata;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [lhs_pkg::APB_ADDR_W-1:0]     paddr = '0;
    logic [lhs_pkg::APB_DATA_W-1:0]     pwdata = '0;
    logic [lhs_pkg::APB_DATA_W-1:0]     prdata;
    logic                               pready;

    // Register copies, kept in step with every write.
    bit                                 cfg_enable = 1'b0;
    bit [15:0]                          cfg_width = lhs_pkg::BUCKET_WIDTH_US_RST;
    bit [10:0]                          cfg_buckets = lhs_pkg::NUM_BUCKETS_RST;
    bit [23:0]                          cfg_break = lhs_pkg::BREAK_US_RST;

    // Statistics state of the predictor.
    bit [47:0]                          round_count = '0;
    bit [47:0]                          lat_min = '1;
    bit [47:0]                          lat_max = '0;
    bit [63:0]                          lat_sum = '0;
    bit [31:0]                          bucket_count [HIST_DEPTH];

    stats_result_t                      pending_stats [$];
    int                                 mismatches = 0;
    int                                 quiet_cycles = 0;
    int                                 stall_left = 0;
    bit                                 idle_on = 1'b1;

    latency_histogram_stats i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input bit [63:0] got,
                                   input bit [63:0] want);
        $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Applies one item to the statistics and returns the snapshot it produces.
    function automatic stats_result_t predict_stats(input bit func, input bit [47:0] lat,
                                                    input bit [9:0] idx);
        stats_result_t r;
        bit [63:0]     used;
        bit [63:0]     div_ns;
        bit [63:0]     quot;
        bit [63:0]     slot;
        r = '0;
        if (func == FUNC_READ)
        begin
            if (idx < HIST_DEPTH)
                r.read_count = bucket_count[idx];
        end
        else
        begin
            if (round_count != '1)
                round_count++;
            if (round_count >= WARMUP_COUNT)
            begin
                r.sample_counted = 1'b1;
                if (cfg_enable)
                begin
                    used = (cfg_buckets == 0) ? 64'd1 : 64'(cfg_buckets);
                    if (used > HIST_DEPTH)
                        used = HIST_DEPTH;
                    div_ns = 64'(cfg_width) * lhs_pkg::NS_PER_US;
                    quot = (div_ns == 0) ? '1 : 64'(lat) / div_ns;
                    slot = (quot < used - 1) ? quot : used - 1;
                    if (bucket_count[slot] != '1)
                        bucket_count[slot]++;
                end
                if (~lat_sum < 64'(lat))
                    lat_sum = '1;
                else
                    lat_sum += 64'(lat);
                if (lat < lat_min)
                    lat_min = lat;
                if (lat > lat_max)
                begin
                    lat_max = lat;
                    if (cfg_break != 0 &&
                        64'(lat_max) > 64'(cfg_break) * lhs_pkg::NS_PER_US)
                        r.threshold_hit = 1'b1;
                end
            end
        end
        r.rounds = round_count;
        r.min_ns = lat_min;
        r.max_ns = lat_max;
        r.sum_ns = lat_sum;
        return r;
    endfunction

    // Offers one item, after an occasional gap, and records its expected result.
    task automatic send_item(input bit func, input bit [47:0] lat, input bit [9:0] idx);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {6'b0, idx, lat};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_stats.push_back(predict_stats(func, lat, idx));
    endtask

    task automatic send_sample(input bit [47:0] lat);
        send_item(FUNC_SAMPLE, lat, 10'($urandom()));
    endtask

    task automatic send_read(input bit [9:0] idx);
        send_item(FUNC_READ, {$urandom(), $urandom()}, idx);
    endtask

    // Stops the input and waits until every expected result has arrived.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Writes one register, with junk above the field at times, and reads it back.
    task automatic write_reg(input logic [1:0] idx, input bit [31:0] value);
        bit [31:0] mask;
        bit [31:0] data;
        bit [31:0] got;
        case (idx)
            lhs_pkg::REG_HIST_ENABLE:     mask = 32'h0000_0001;
            lhs_pkg::REG_BUCKET_WIDTH_US: mask = 32'h0000_FFFF;
            lhs_pkg::REG_NUM_BUCKETS:     mask = 32'h0000_07FF;
            default:                      mask = 32'h00FF_FFFF;
        endcase
        data = value & mask;
        if ($urandom_range(0, 1) == 1)
            data |= $urandom() & ~mask;

        // Write: setup, then access.
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            lhs_pkg::REG_HIST_ENABLE:     cfg_enable = data[0];
            lhs_pkg::REG_BUCKET_WIDTH_US: cfg_width = data[15:0];
            lhs_pkg::REG_NUM_BUCKETS:     cfg_buckets = data[10:0];
            default:                      cfg_break = data[23:0];
        endcase

        // Read back the same register.
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got != (data & mask))
            report_mismatch("register read-back", 64'(got), 64'(data & mask));
    endtask

    task automatic set_config(input bit en, input bit [31:0] width, input bit [31:0] nb,
                              input bit [31:0] brk);
        wait_idle();
        write_reg(lhs_pkg::REG_HIST_ENABLE, 32'(en));
        write_reg(lhs_pkg::REG_BUCKET_WIDTH_US, width);
        write_reg(lhs_pkg::REG_NUM_BUCKETS, nb);
        write_reg(lhs_pkg::REG_BREAK_US, brk);
    endtask

    // Random mix of samples and bucket reads shaped by the current settings.
    task automatic run_random_phase(input int count, input bit wide);
        bit [63:0] used;
        bit [63:0] width_ns;
        bit [47:0] lat;
        bit [9:0]  idx;
        int        pick;
        for (int n = 0; n < count; n++)
        begin
            used = (cfg_buckets == 0) ? 64'd1 : 64'(cfg_buckets);
            if (used > HIST_DEPTH)
                used = HIST_DEPTH;
            width_ns = 64'(cfg_width) * lhs_pkg::NS_PER_US;
            if (width_ns == 0)
                width_ns = lhs_pkg::NS_PER_US;
            if ($urandom_range(0, 9) < 6)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    lat = 48'(width_ns * $urandom_range(0, 32'(used)) + $urandom() % width_ns);
                else if (pick < 7 && lat_max < 48'hFFFF_0000_0000)
                    lat = lat_max + 48'($urandom_range(1, 1 << 20));
                else if (pick < 9)
                    lat = 48'($urandom_range(0, 100000));
                else if (wide)
                    lat = 48'({$urandom(), $urandom()});
                else
                    lat = 48'($urandom());
                send_sample(lat);
            end
            else
            begin
                if ($urandom_range(0, 9) < 7)
                    idx = 10'($urandom_range(0, 32'(used) - 1));
                else
                    idx = 10'($urandom());
                send_read(idx);
            end
        end
    endtask

    // Buckets read straight after reset hold zero, with default statistics.
    task automatic test_reset_state();
        send_read(10'd0);
        send_read(10'd1023);
        send_read(10'($urandom()));
    endtask

    // The first rounds are ignored; the round that reaches the limit is counted.
    task automatic test_warmup();
        set_config(1'b1, 1, 8, 1);
        for (int n = 1; n < WARMUP_COUNT; n++)
        begin
            if (n == 1)
                send_sample('0);
            else if (n == 2)
                send_sample('1);
            else
                send_sample(48'({$urandom(), $urandom()}));
            if (n == 20)
                send_read(10'd7);
        end
        send_sample(48'd0);
    endtask

    // Threshold edges and the bucket clamping cases.
    task automatic test_threshold_and_buckets();
        send_sample(48'd999);
        send_sample(48'd1000);
        send_sample(48'd1001);
        send_sample(48'd1001);
        // Disabled threshold: a new max raises nothing.
        set_config(1'b1, 1, 8, 0);
        send_sample(48'd5000);
        set_config(1'b1, 1, 8, 2);
        send_sample(48'd2500);
        send_sample(48'd9000);
        // Zero width sends the sample to the last bucket in use.
        set_config(1'b1, 0, 8, 2);
        send_sample(48'd123);
        // Zero bucket count acts as one bucket.
        set_config(1'b1, 1, 0, 2);
        send_sample(48'd4000);
        // A count above the memory depth is clamped to it.
        set_config(1'b1, 1, 2047, 2);
        send_sample(48'd2000000);
        set_config(1'b0, 1, 8, 2);
        send_sample(48'd3000);
        send_read(10'd0);
        send_read(10'd1);
        send_read(10'd5);
        send_read(10'd7);
        send_read(10'd1023);
    endtask

    // Several register settings, the extremes among them.
    task automatic test_random_configs();
        set_config(1'b1, 10, 1024, 50);
        run_random_phase(80, 1'b0);
        set_config(1'b1, 1, 1, 1);
        run_random_phase(60, 1'b0);
        set_config(1'b1, 0, 16, 32'(lat_max / 1000) + 20);
        run_random_phase(60, 1'b0);
        set_config(1'b0, 65535, 2047, 0);
        run_random_phase(60, 1'b0);
        set_config(1'b1, 65535, 0, 24'hFF_FFFF);
        run_random_phase(60, 1'b0);
        set_config(1'b1, $urandom_range(1, 300), $urandom_range(1, 1024), $urandom());
        run_random_phase(60, 1'b1);
        // From here on neither side idles.
        wait_idle();
        idle_on = 1'b0;
        set_config(1'b1, 3, 1024, $urandom_range(1, 1000000));
        run_random_phase(60, 1'b1);
    endtask

    // Largest samples, first with the histogram off and then on.
    task automatic test_large_samples();
        set_config(1'b0, 10, 1024, 1);
        for (int n = 0; n < 24; n++)
            send_sample('1);
        set_config(1'b1, 10, 1024, 1);
        send_sample('1);
        send_sample(48'd17);
        send_read(10'd1023);
    endtask

    // Sink side: random stall bursts while idling is allowed.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 16) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        stats_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_stats.size() == 0)
            begin
                report_mismatch("result with nothing expected", 64'(m_tdata[81:34]), '0);
            end
            else
            begin
                want = pending_stats.pop_front();
                if (m_tdata[0] != want.threshold_hit)
                    report_mismatch("threshold_hit", 64'(m_tdata[0]), 64'(want.threshold_hit));
                if (m_tdata[1] != want.sample_counted)
                    report_mismatch("sample_counted", 64'(m_tdata[1]),
                                    64'(want.sample_counted));
                if (m_tdata[33:2] != want.read_count)
                    report_mismatch("read_count", 64'(m_tdata[33:2]), 64'(want.read_count));
                if (m_tdata[81:34] != want.rounds)
                    report_mismatch("rounds_seen", 64'(m_tdata[81:34]), 64'(want.rounds));
                if (m_tdata[129:82] != want.min_ns)
                    report_mismatch("min_seen", 64'(m_tdata[129:82]), 64'(want.min_ns));
                if (m_tdata[177:130] != want.max_ns)
                    report_mismatch("max_seen", 64'(m_tdata[177:130]), 64'(want.max_ns));
                if (m_tdata[241:178] != want.sum_ns)
                    report_mismatch("sum_seen", 64'(m_tdata[241:178]), want.sum_ns);
            end
        end
    end

    // Ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
            $display("latency_histogram_stats_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_warmup();
        test_threshold_and_buckets();
        test_random_configs();
        test_large_samples();
        wait_idle();
        repeat (20) @(posedge clk);
        if (pending_stats.size() != 0)
            report_mismatch("results still expected", 64'(pending_stats.size()), '0);
        if (mismatches == 0)
            $display("latency_histogram_stats_test OK");
        else
            $display("latency_histogram_stats_test NOT OK");
        $finish;
    end

endmodule
